>>> hw/rtl/lph_pkg.sv
`default_nettype none
package lph_pkg;

  // Number of slots in the table.
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // Field widths.
  localparam int DIV_W     = 6;
  localparam int DAY_W     = 5;
  localparam int SLOT_W    = 5;
  localparam int DETAILS_W = 61;

  // Width of the shared subtract and compare unit. It must hold a shifted
  // partial remainder (one bit wider than the divisor) and TABLE_SIZE itself.
  localparam int UNIT_W = (IDX_W + 2 > DIV_W + 1) ? IDX_W + 2 : DIV_W + 1;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(10);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] name_code;
    logic [63:0] job_code;
    logic [4:0]  day_of_birth;
    logic [3:0]  month_of_birth;
    logic [11:0] year_of_birth;
    logic [7:0]  work_years;
    logic [31:0] salary_amount;
  } in_word_t;

  typedef struct packed {
    logic             success;
    logic [SLOT_W-1:0] slot_index;
    logic             table_full;
  } out_word_t;

  typedef struct packed {
    logic [63:0]          name;
    logic [63:0]          job;
    logic [DETAILS_W-1:0] details;
  } record_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRAP,
    ST_PROBE
  } state_t;

  // Packs the date, work years and salary as one stored details field.
  function automatic logic [DETAILS_W-1:0] pack_details(input in_word_t w);
    pack_details = {w.salary_amount, w.work_years, w.year_of_birth,
                    w.month_of_birth, w.day_of_birth};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/linear_probe_hash_table.sv
`default_nettype none
// Steps: remainder steps over the day bits with a nonzero divisor (none for a zero divisor, whose
// remainder is the day itself), then the wrap state, which subtracts TABLE_SIZE while it fits, then
// the probe over the slots; the result word is registered and shows the cycle after the last probe.
// Throughput: one word at a time; a new word is accepted only in idle, after the last one's probe.
// The probe reads one record slot per cycle, holding on its last slot until the result register is free.
// Reset (rst_n, synchronous, active low): all slot valid bits clear, divisor back to 10.
module linear_probe_hash_table
  import lph_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,

  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,

  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word,

  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [DIV_W-1:0] cfg_data
);

  // Control registers.
  state_t                state_r, state_nxt;
  logic [DIV_W-1:0]      divisor_r;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload registers.
  in_word_t              item_r, item_nxt;
  logic [UNIT_W-1:0]     rem_r, rem_nxt;
  out_word_t             out_word_r, out_word_nxt;
  record_t               rd_data_r;

  // Record memory: one read port registered, one write port.
  record_t               mem [TABLE_SIZE];
  logic                  mem_we;
  record_t               wr_rec;

  // Shared subtract and compare unit.
  logic [UNIT_W-1:0]     unit_a, unit_b, unit_diff;
  logic                  unit_ge;

  logic                  in_acc;
  logic                  out_free;
  logic                  slot_busy;
  logic                  last_step;
  logic                  rec_match;
  logic [IDX_W-1:0]      slot_inc;
  logic [UNIT_W-1:0]     rem_shift;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

  assign wr_rec    = '{name: item_r.name_code, job: item_r.job_code,
                       details: pack_details(item_r)};
  assign slot_busy = valid_r[slot_r];
  assign rec_match = (rd_data_r == wr_rec);
  assign last_step = (step_r == IDX_W'(TABLE_SIZE - 1));
  assign slot_inc  = (slot_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : slot_r + 1'b1;
  assign rem_shift = {rem_r[UNIT_W-2:0], item_r.day_of_birth[bit_r]};

  // During the remainder steps the unit compares the shifted partial remainder
  // with the divisor; in the wrap state it folds the remainder into the table.
  always_comb begin
    if (state_r == ST_DIV) begin
      unit_a = rem_shift;
      unit_b = UNIT_W'(divisor_r);
    end else begin
      unit_a = rem_r;
      unit_b = UNIT_W'(TABLE_SIZE);
    end
    unit_diff = unit_a - unit_b;
    unit_ge   = (unit_a >= unit_b);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (divisor_r == '0) ? ST_WRAP : ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_r == '0) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (!unit_ge) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // A probe ends on an empty slot, a match on find, or the last step,
        // but only once the result register is free.
        if (out_free && (!slot_busy || last_step ||
                         (item_r.kind == KIND_FIND && rec_match))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_nxt      = item_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    slot_nxt      = slot_r;
    step_nxt      = step_r;
    valid_nxt     = valid_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_word;
          bit_nxt  = 3'(DAY_W - 1);
          rem_nxt  = (divisor_r == '0) ? UNIT_W'(in_word.day_of_birth) : '0;
        end
      end
      ST_DIV: begin
        rem_nxt = unit_ge ? unit_diff : rem_shift;
        bit_nxt = bit_r - 1'b1;
      end
      ST_WRAP: begin
        if (unit_ge) begin
          rem_nxt = unit_diff;
        end else begin
          slot_nxt = rem_r[IDX_W-1:0];
          step_nxt = '0;
        end
      end
      ST_PROBE: begin
        if (item_r.kind == KIND_INSERT) begin
          if (!slot_busy) begin
            if (out_free) begin
              mem_we            = 1'b1;
              valid_nxt[slot_r] = 1'b1;
              out_valid_nxt     = 1'b1;
              out_word_nxt      = '{success: 1'b1, slot_index: SLOT_W'(slot_r),
                                    table_full: 1'b0};
            end
          end else if (last_step) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{success: 1'b0, slot_index: '0, table_full: 1'b1};
            end
          end else begin
            slot_nxt = slot_inc;
            step_nxt = step_r + 1'b1;
          end
        end else begin
          if (!slot_busy || (!rec_match && last_step)) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{success: 1'b0, slot_index: '0, table_full: 1'b0};
            end
          end else if (rec_match) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{success: 1'b1, slot_index: SLOT_W'(slot_r),
                                    table_full: 1'b0};
            end
          end else begin
            slot_nxt = slot_inc;
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      divisor_r   <= DIVISOR_RESET;
      valid_r     <= '0;
      bit_r       <= '0;
      slot_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      bit_r       <= bit_nxt;
      slot_r      <= slot_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        divisor_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    out_word_r <= out_word_nxt;
  end

  // The read address is the slot of the next cycle, so the registered read
  // data always belongs to the slot being probed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= wr_rec;
    end
    rd_data_r <= mem[slot_nxt];
  end

  // An insert never overwrites an occupied slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !valid_r[slot_r])
    else $error("insert wrote an occupied slot");

  // A stored record marks its slot valid.
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(slot_r)])
    else $error("stored slot not marked valid");

  // A full-table flag never comes with success.
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.success && out_word_r.table_full))
    else $error("success and table_full both set");

  // An accepted word always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted word did not start a search");

endmodule
`default_nettype wire
